FILE: src/bct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier tessellator package
// Shared widths, codes and the request, result, command and status types.
// ----------------------------------------------------------------------------
package bct_pkg;

  localparam int COORD_W     = 16;
  localparam int SEG_W       = 7;
  localparam int SEG_MAX     = 127;
  localparam int MAX_SEG_DEF = 64;
  localparam int ONE_W       = 17;
  localparam int HALF_W      = 24;
  localparam int WORK_W      = 48;
  localparam int SUM_W       = 64;
  localparam int PROD_W      = HALF_W + ONE_W;
  localparam int QUAD_SHIFT  = 32;
  localparam int CUBIC_SHIFT = 48;

  localparam logic [ONE_W-1:0]   ONE_Q16   = 17'h10000;
  localparam logic [COORD_W-1:0] SIGN_FLIP = 16'h8000;

  localparam logic OP_QUAD  = 1'b0;
  localparam logic OP_CUBIC = 1'b1;

  localparam logic [1:0] LVL_FIRST = 2'd1;
  localparam logic [1:0] DEG_QUAD  = 2'd2;
  localparam logic [1:0] DEG_CUBIC = 2'd3;

  typedef struct packed {
    logic                      operation;
    logic signed [COORD_W-1:0] p0_x;
    logic signed [COORD_W-1:0] p0_y;
    logic signed [COORD_W-1:0] p1_x;
    logic signed [COORD_W-1:0] p1_y;
    logic signed [COORD_W-1:0] p2_x;
    logic signed [COORD_W-1:0] p2_y;
    logic signed [COORD_W-1:0] p3_x;
    logic signed [COORD_W-1:0] p3_y;
    logic [SEG_W-1:0]          segment_count;
  } bct_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } bct_out_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       mul;
    logic       wr;
    logic       emit;
    logic [1:0] lvl;
    logic [1:0] idx;
  } bct_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic cubic;
    logic last;
    logic out_free;
  } bct_stat_t;

endpackage
`default_nettype wire

FILE: src/bct_recip.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Step divider
// Restoring divider that forms 65536 / n, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bct_recip import bct_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SEG_W-1:0] divisor,
  output logic      [ONE_W-1:0] quotient,
  output logic      [SEG_W-1:0] remainder,
  output logic                  busy
);

  localparam int CNT_W = $clog2(ONE_W);

  logic [CNT_W-1:0] cnt;
  logic [SEG_W:0]   trial;
  logic [SEG_W:0]   trial_sub;
  logic             fits;

  always_comb begin
    trial     = {remainder, (cnt == CNT_W'(ONE_W - 1))};
    trial_sub = trial - {1'b0, divisor};
    fits      = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(ONE_W - 1);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= '0;
      remainder <= '0;
    end else if (busy) begin
      quotient  <= {quotient[ONE_W-2:0], fits};
      remainder <= fits ? trial_sub[SEG_W-1:0] : trial[SEG_W-1:0];
    end
  end

endmodule
`default_nettype wire

FILE: src/bct_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Coordinate lane
// Exact de Casteljau evaluation of one coordinate with a shared interpolator.
// ----------------------------------------------------------------------------
module bct_lane import bct_pkg::*; (
  input  wire logic               clk,
  input  wire bct_cmd_t           cmd,
  input  wire logic               cubic,
  input  wire logic [COORD_W-1:0] c0,
  input  wire logic [COORD_W-1:0] c1,
  input  wire logic [COORD_W-1:0] c2,
  input  wire logic [COORD_W-1:0] c3,
  input  wire logic [ONE_W-1:0]   a,
  input  wire logic [ONE_W-1:0]   t,
  output logic      [COORD_W-1:0] coord
);

  localparam int ACC_W = SUM_W + 2;

  logic [COORD_W-1:0] cp0, cp1, cp2, cp3;
  logic [WORK_W-1:0]  w0, w1, w2;
  logic [SUM_W-1:0]   res;
  logic [WORK_W-1:0]  src_a, src_b;
  logic [PROD_W-1:0]  pah, pal, pbh, pbl;
  logic [ACC_W-1:0]   lerp_sum;
  logic [1:0]         deg;
  logic               final_op;
  logic [SUM_W-1:0]   round_q, round_c;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cp0 <= c0 ^ SIGN_FLIP;
      cp1 <= c1 ^ SIGN_FLIP;
      cp2 <= c2 ^ SIGN_FLIP;
      cp3 <= c3 ^ SIGN_FLIP;
    end
  end

  always_comb begin
    src_a = '0;
    src_b = '0;
    if (cmd.lvl == LVL_FIRST) begin
      case (cmd.idx)
        2'd0: begin
          src_a = WORK_W'(cp0);
          src_b = WORK_W'(cp1);
        end
        2'd1: begin
          src_a = WORK_W'(cp1);
          src_b = WORK_W'(cp2);
        end
        default: begin
          src_a = WORK_W'(cp2);
          src_b = WORK_W'(cp3);
        end
      endcase
    end else begin
      case (cmd.idx)
        2'd0: begin
          src_a = w0;
          src_b = w1;
        end
        default: begin
          src_a = w1;
          src_b = w2;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      pah <= PROD_W'(src_a[WORK_W-1:HALF_W]) * PROD_W'(a);
      pal <= PROD_W'(src_a[HALF_W-1:0]) * PROD_W'(a);
      pbh <= PROD_W'(src_b[WORK_W-1:HALF_W]) * PROD_W'(t);
      pbl <= PROD_W'(src_b[HALF_W-1:0]) * PROD_W'(t);
    end
  end

  always_comb begin
    lerp_sum = (ACC_W'(pah) << HALF_W) + ACC_W'(pal)
             + (ACC_W'(pbh) << HALF_W) + ACC_W'(pbl);
    deg      = cubic ? DEG_CUBIC : DEG_QUAD;
    final_op = (cmd.lvl == deg);
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      if (final_op) begin
        res <= lerp_sum[SUM_W-1:0];
      end else begin
        case (cmd.idx)
          2'd0:    w0 <= lerp_sum[WORK_W-1:0];
          2'd1:    w1 <= lerp_sum[WORK_W-1:0];
          default: w2 <= lerp_sum[WORK_W-1:0];
        endcase
      end
    end
  end

  always_comb begin
    round_q = res + (SUM_W'(1) << (QUAD_SHIFT - 1));
    round_c = res + (SUM_W'(1) << (CUBIC_SHIFT - 1));
    if (cubic) begin
      coord = round_c[CUBIC_SHIFT+COORD_W-1:CUBIC_SHIFT] ^ SIGN_FLIP;
    end else begin
      coord = round_q[QUAD_SHIFT+COORD_W-1:QUAD_SHIFT] ^ SIGN_FLIP;
    end
  end

endmodule
`default_nettype wire

FILE: src/bct_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tessellator datapath
// Parameter stepping, two coordinate lanes and the output register.
// ----------------------------------------------------------------------------
module bct_datapath import bct_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire bct_cmd_t  cmd,
  output bct_stat_t      stat,
  input  wire bct_in_t   curve,
  output logic           point_valid,
  input  wire logic      point_stall,
  output bct_out_t       point
);

  localparam int SAT_SEG = (MAX_SEGMENTS < SEG_MAX) ? MAX_SEGMENTS : SEG_MAX;

  logic             cubic;
  logic [SEG_W-1:0] n, k, r, seg_clamped;
  logic [SEG_W-1:0] step_rem;
  logic [ONE_W-1:0] q, step_quo, a_w;
  logic [SEG_W:0]   r_sum, r_sub;
  logic             r_wrap;
  logic             div_busy;
  logic [COORD_W-1:0] x_coord, y_coord;

  always_comb begin
    if (curve.segment_count == '0) begin
      seg_clamped = SEG_W'(1);
    end else if (curve.segment_count > SEG_W'(SAT_SEG)) begin
      seg_clamped = SEG_W'(SAT_SEG);
    end else begin
      seg_clamped = curve.segment_count;
    end
    r_sum  = {1'b0, r} + {1'b0, step_rem};
    r_sub  = r_sum - {1'b0, n};
    r_wrap = (r_sum >= {1'b0, n});
    a_w    = ONE_Q16 - q;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cubic <= (curve.operation == OP_CUBIC);
      n     <= seg_clamped;
      k     <= '0;
      q     <= '0;
      r     <= seg_clamped >> 1;
    end else if (cmd.step) begin
      k <= k + SEG_W'(1);
      q <= q + step_quo + ONE_W'(r_wrap);
      r <= r_wrap ? r_sub[SEG_W-1:0] : r_sum[SEG_W-1:0];
    end
  end

  bct_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.load),
    .divisor   (n),
    .quotient  (step_quo),
    .remainder (step_rem),
    .busy      (div_busy)
  );

  bct_lane u_lane_x (
    .clk   (clk),
    .cmd   (cmd),
    .cubic (cubic),
    .c0    (curve.p0_x),
    .c1    (curve.p1_x),
    .c2    (curve.p2_x),
    .c3    (curve.p3_x),
    .a     (a_w),
    .t     (q),
    .coord (x_coord)
  );

  bct_lane u_lane_y (
    .clk   (clk),
    .cmd   (cmd),
    .cubic (cubic),
    .c0    (curve.p0_y),
    .c1    (curve.p1_y),
    .c2    (curve.p2_y),
    .c3    (curve.p3_y),
    .a     (a_w),
    .t     (q),
    .coord (y_coord)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
    end else if (cmd.emit) begin
      point_valid <= 1'b1;
    end else if (!point_stall) begin
      point_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point.point_x    <= x_coord;
      point.point_y    <= y_coord;
      point.last_point <= (k == n);
    end
  end

  always_comb begin
    stat.div_busy = div_busy;
    stat.cubic    = cubic;
    stat.last     = (k == n);
    stat.out_free = !point_valid || !point_stall;
  end

endmodule
`default_nettype wire

FILE: src/bct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tessellator controller
// Sequences division, parameter steps, interpolation passes and output.
// ----------------------------------------------------------------------------
module bct_ctrl import bct_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      curve_valid,
  output logic           curve_stall,
  output bct_cmd_t       cmd,
  input  wire bct_stat_t stat
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_STEP = 6'b000100,
    S_MUL  = 6'b001000,
    S_ADD  = 6'b010000,
    S_EMIT = 6'b100000
  } state_t;

  state_t     state, state_next;
  logic [1:0] lvl, lvl_next;
  logic [1:0] idx, idx_next;
  logic [1:0] deg;

  assign curve_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    lvl_next   = lvl;
    idx_next   = idx;
    deg        = stat.cubic ? DEG_CUBIC : DEG_QUAD;
    cmd        = '0;
    cmd.lvl    = lvl;
    cmd.idx    = idx;
    case (state)
      S_IDLE: begin
        if (curve_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        lvl_next   = LVL_FIRST;
        idx_next   = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.wr = 1'b1;
        if (idx == deg - lvl) begin
          if (lvl == deg) begin
            state_next = S_EMIT;
          end else begin
            lvl_next   = lvl + 2'd1;
            idx_next   = '0;
            state_next = S_MUL;
          end
        end else begin
          idx_next   = idx + 2'd1;
          state_next = S_MUL;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = stat.last ? S_IDLE : S_STEP;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lvl   <= LVL_FIRST;
      idx   <= '0;
    end else begin
      state <= state_next;
      lvl   <= lvl_next;
      idx   <= idx_next;
    end
  end

`ifndef SYNTHESIS
  a_load_starts_div: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == S_DIV))
    else $error("A new request did not start the divider.");

  a_mul_then_write: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |=> cmd.wr)
    else $error("An interpolation pass was not written back.");

  a_emit_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("A point was loaded over one still waiting.");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.last) |=> (state == S_IDLE))
    else $error("The final point did not end the request.");
`endif

endmodule
`default_nettype wire

FILE: src/bezier_curve_tessellator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bezier curve tessellator
// Emits n points of a quadratic or cubic curve at t = k/n, k = 1 .. n.
// ----------------------------------------------------------------------------
// Each request carries a degree select, four Q8.8 control points and a segment
// count n (zero counts as one, counts above MAX_SEGMENTS saturate). The block
// returns n points, the last one exactly at the end point and flagged with
// last_point. Each request is first set up while a bit-serial divider forms the
// parameter step 65536/n; then for each point the x and y lanes each share one
// interpolator that runs the de Casteljau passes in order. A new request is
// taken in the cycle after the last point enters the output register.
// ----------------------------------------------------------------------------
module bezier_curve_tessellator import bct_pkg::*; #(
  parameter int MAX_SEGMENTS = MAX_SEG_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     curve_valid,
  output logic          curve_stall,
  input  wire bct_in_t  curve,
  output logic          point_valid,
  input  wire logic     point_stall,
  output bct_out_t      point
);

  bct_cmd_t  cmd;
  bct_stat_t stat;

  bct_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .curve_valid (curve_valid),
    .curve_stall (curve_stall),
    .cmd         (cmd),
    .stat        (stat)
  );

  bct_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .curve       (curve),
    .point_valid (point_valid),
    .point_stall (point_stall),
    .point       (point)
  );

endmodule
`default_nettype wire

FILE: sim/bezier_curve_tessellator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bezier curve tessellator testbench
// Sends quadratic and cubic curve requests with directed extremes, segment
// count limits and random content, predicts every point from the Bernstein form
// in Q8.8, and checks them in order, also under sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module bezier_curve_tessellator_tb;
  import bct_pkg::*;

  localparam int MAX_SEGMENTS = MAX_SEG_DEF;
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int RANDOM_PER_PHASE = 120;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     curve_valid = 1'b0;
  logic     curve_stall;
  bct_in_t  curve = '0;
  logic     point_valid;
  logic     point_stall = 1'b0;
  bct_out_t point;

  bct_out_t expected_points[$];
  int       send_idle_pct = 0;
  int       point_stall_pct = 0;
  int       error_count = 0;
  int       curves_sent = 0;
  int       points_checked = 0;
  int       cycle_count = 0;

  bezier_curve_tessellator #(.MAX_SEGMENTS(MAX_SEGMENTS)) dut (
    .clk(clk),
    .rst(rst),
    .curve_valid(curve_valid),
    .curve_stall(curve_stall),
    .curve(curve),
    .point_valid(point_valid),
    .point_stall(point_stall),
    .point(point)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk) begin
    point_stall <= ($urandom_range(99) < point_stall_pct);
  end

  function automatic logic [15:0] blend_coord(logic cubic, logic [15:0] c0, logic [15:0] c1,
                                              logic [15:0] c2, logic [15:0] c3,
                                              logic [63:0] t);
    logic [63:0] a;
    logic [63:0] o0, o1, o2, o3;
    logic [63:0] acc;
    a  = 64'd65536 - t;
    o0 = {48'd0, c0 ^ SIGN_FLIP};
    o1 = {48'd0, c1 ^ SIGN_FLIP};
    o2 = {48'd0, c2 ^ SIGN_FLIP};
    o3 = {48'd0, c3 ^ SIGN_FLIP};
    if (cubic) begin
      acc = o0 * (a * a * a) + o1 * (64'd3 * a * a * t)
          + o2 * (64'd3 * a * t * t) + o3 * (t * t * t);
      acc = (acc + (64'd1 << (CUBIC_SHIFT - 1))) >> CUBIC_SHIFT;
    end else begin
      acc = o0 * (a * a) + o1 * (64'd2 * a * t) + o2 * (t * t);
      acc = (acc + (64'd1 << (QUAD_SHIFT - 1))) >> QUAD_SHIFT;
    end
    return acc[15:0] ^ SIGN_FLIP;
  endfunction

  function automatic void predict_curve_points(bct_in_t c);
    logic [63:0] n;
    logic [63:0] t;
    bct_out_t    p;
    n = {57'd0, c.segment_count};
    if (n == 0) n = 1;
    if (n > MAX_SEGMENTS) n = MAX_SEGMENTS;
    for (logic [63:0] k = 1; k <= n; k++) begin
      t = (k * 64'd65536 + n / 2) / n;
      if (t > 64'd65536) t = 64'd65536;
      p.point_x    = blend_coord(c.operation == OP_CUBIC, c.p0_x, c.p1_x, c.p2_x, c.p3_x, t);
      p.point_y    = blend_coord(c.operation == OP_CUBIC, c.p0_y, c.p1_y, c.p2_y, c.p3_y, t);
      p.last_point = (k == n);
      expected_points.insert(expected_points.size(), p);
    end
  endfunction

  always @(posedge clk) begin
    bct_out_t want;
    if (!rst && point_valid && !point_stall) begin
      if (expected_points.size() == 0) begin
        $error("unexpected point: x %0d, y %0d, last %0b",
               point.point_x, point.point_y, point.last_point);
        error_count++;
      end else begin
        want = expected_points.pop_front();
        if (point.point_x !== want.point_x) begin
          $error("point_x: expected %0d, got %0d", want.point_x, point.point_x);
          error_count++;
        end
        if (point.point_y !== want.point_y) begin
          $error("point_y: expected %0d, got %0d", want.point_y, point.point_y);
          error_count++;
        end
        if (point.last_point !== want.last_point) begin
          $error("last_point: expected %0b, got %0b", want.last_point, point.last_point);
          error_count++;
        end
        points_checked++;
      end
    end
  end

  task automatic send_curve(bct_in_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      curve_valid <= 1'b0;
      @(posedge clk);
    end
    curve       <= c;
    curve_valid <= 1'b1;
    do @(posedge clk); while (curve_stall);
    predict_curve_points(c);
    curves_sent++;
  endtask

  task automatic wait_for_all_points();
    curve_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
  endtask

  function automatic bct_in_t make_curve(logic op, logic [15:0] x0, logic [15:0] y0,
                                         logic [15:0] x1, logic [15:0] y1,
                                         logic [15:0] x2, logic [15:0] y2,
                                         logic [15:0] x3, logic [15:0] y3,
                                         logic [6:0] segs);
    bct_in_t c;
    c.operation = op;
    c.p0_x = x0;
    c.p0_y = y0;
    c.p1_x = x1;
    c.p1_y = y1;
    c.p2_x = x2;
    c.p2_y = y2;
    c.p3_x = x3;
    c.p3_y = y3;
    c.segment_count = segs;
    return c;
  endfunction

  function automatic logic [15:0] random_coord();
    case ($urandom_range(3))
      0: begin
        case ($urandom_range(3))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'h0000;
          default: return 16'hffff;
        endcase
      end
      1: return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] random_segments();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 7'($urandom_range(8, 1));
    if (r < 80) return 7'd0;
    if (r < 90) return 7'($urandom_range(63, 9));
    if (r < 95) return 7'(MAX_SEGMENTS);
    return 7'($urandom_range(127, 65));
  endfunction

  function automatic bct_in_t random_curve();
    bct_in_t c;
    c.operation = ($urandom_range(1) == 1) ? OP_CUBIC : OP_QUAD;
    c.p0_x = random_coord();
    c.p0_y = random_coord();
    c.p1_x = random_coord();
    c.p1_y = random_coord();
    c.p2_x = random_coord();
    c.p2_y = random_coord();
    c.p3_x = random_coord();
    c.p3_y = random_coord();
    c.segment_count = random_segments();
    return c;
  endfunction

  task automatic test_extreme_points();
    send_curve(make_curve(OP_QUAD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 7'd4));
    send_curve(make_curve(OP_QUAD, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000, 7'd4));
    send_curve(make_curve(OP_CUBIC, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 7'd4));
    send_curve(make_curve(OP_CUBIC, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                          16'h8000, 16'h8000, 16'h8000, 16'h8000, 7'd4));
    send_curve(make_curve(OP_CUBIC, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                          16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 7'd7));
    send_curve(make_curve(OP_QUAD, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                          16'h8000, 16'h7fff, 16'h0000, 16'h0000, 7'd5));
    send_curve(make_curve(OP_CUBIC, 16'h0000, 16'h0000, 16'hffff, 16'h0001,
                          16'h0001, 16'hffff, 16'h0000, 16'h0000, 7'd1));
    wait_for_all_points();
  endtask

  task automatic test_segment_limits();
    // A zero count behaves as one segment and counts past the maximum saturate.
    send_curve(make_curve(OP_QUAD, 16'h1200, 16'hf000, 16'h0400, 16'h0300,
                          16'hff00, 16'h2000, 16'h0000, 16'h0000, 7'd0));
    send_curve(make_curve(OP_CUBIC, 16'h1200, 16'hf000, 16'h0400, 16'h0300,
                          16'hff00, 16'h2000, 16'h7777, 16'h8888, 7'd0));
    send_curve(make_curve(OP_CUBIC, 16'h0100, 16'h0200, 16'h0300, 16'h0400,
                          16'h0500, 16'h0600, 16'h0700, 16'h0800, 7'd1));
    send_curve(make_curve(OP_QUAD, 16'h0100, 16'h0200, 16'h0300, 16'h0400,
                          16'h0500, 16'h0600, 16'h0700, 16'h0800, 7'd2));
    send_curve(make_curve(OP_CUBIC, 16'hc000, 16'h4000, 16'h4000, 16'hc000,
                          16'hc000, 16'hc000, 16'h4000, 16'h4000, 7'd3));
    send_curve(make_curve(OP_CUBIC, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'h8000, 16'h8000, 16'h7fff, 16'h8000, 7'd63));
    send_curve(make_curve(OP_CUBIC, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                          16'h8000, 16'h8000, 16'h7fff, 16'h8000, 7'(MAX_SEGMENTS)));
    send_curve(make_curve(OP_QUAD, 16'h0a55, 16'hf5aa, 16'h7fff, 16'h8000,
                          16'h0000, 16'h0000, 16'h5a5a, 16'ha5a5, 7'd65));
    send_curve(make_curve(OP_CUBIC, 16'h0a55, 16'hf5aa, 16'h7fff, 16'h8000,
                          16'h0000, 16'h0000, 16'h5a5a, 16'ha5a5, 7'd127));
    // In a quadratic request the fourth point must have no effect.
    send_curve(make_curve(OP_QUAD, 16'h0300, 16'h0300, 16'hfd00, 16'h0100,
                          16'h0100, 16'hfd00, 16'h7fff, 16'h7fff, 7'd6));
    send_curve(make_curve(OP_QUAD, 16'h0300, 16'h0300, 16'hfd00, 16'h0100,
                          16'h0100, 16'hfd00, 16'h8000, 16'h8000, 7'd6));
    wait_for_all_points();
  endtask

  task automatic test_random_curves();
    int idle_by_phase[4]  = '{0, 45, 0, 22};
    int stall_by_phase[4] = '{0, 0, 45, 22};
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct   = idle_by_phase[phase];
      point_stall_pct = stall_by_phase[phase];
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (i == RANDOM_PER_PHASE / 2) wait_for_all_points();
        send_curve(random_curve());
      end
    end
    send_idle_pct   = 0;
    point_stall_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_points();
    test_segment_limits();
    test_random_curves();
    wait_for_all_points();
    repeat (40) @(posedge clk);
    $display("Checked %0d points from %0d curve requests, quadratic and cubic,",
             points_checked, curves_sent);
    $display("with segment counts 0 to 127 under sender gaps and receiver stalls.");
    if (error_count == 0 && expected_points.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
